### src/clcd_pkg.sv
// Shared types and constants for the character LCD controller write path.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package clcd_pkg;

  // default geometry
  localparam int DEF_DISPLAY_CELLS = 80;
  localparam int DEF_LINE_CELLS    = 40;
  localparam int GLYPH_BYTES       = 64;

  // widest RAM port the block uses
  localparam int RAM_AW = 7;
  localparam int RAM_DW = 8;

  // command codes
  localparam logic [1:0] CMD_INSTR      = 2'd0;
  localparam logic [1:0] CMD_DATA       = 2'd1;
  localparam logic [1:0] CMD_READ_DISP  = 2'd2;
  localparam logic [1:0] CMD_READ_GLYPH = 2'd3;

  // instruction decode patterns
  localparam logic [7:0] FSET_MASK  = 8'he0;
  localparam logic [7:0] FSET_CODE  = 8'h20;
  localparam logic [7:0] DCTL_MASK  = 8'hf8;
  localparam logic [7:0] DCTL_CODE  = 8'h08;
  localparam logic [7:0] CLEAR_CODE = 8'h01;
  localparam logic [7:0] HOME_CODE  = 8'h02;
  localparam logic [7:0] ENTRY_MASK = 8'hfc;
  localparam logic [7:0] ENTRY_CODE = 8'h04;
  localparam logic [7:0] CGSET_MASK = 8'hc0;
  localparam logic [7:0] CGSET_CODE = 8'h40;
  localparam logic [7:0] DDSET_MASK = 8'h80;

  // display fill value for the clear instruction
  localparam logic [7:0] CLEAR_FILL = 8'h20;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_value;
    logic [6:0] read_index;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       display_on;
    logic       cursor_on;
    logic       blink_on;
    logic       two_lines;
    logic       count_up;
    logic       display_selected;
    logic [6:0] display_address;
    logic [5:0] glyph_address;
  } out_t;

  // one RAM's write and read request
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] waddr;
    logic [RAM_DW-1:0] wdata;
    logic [RAM_AW-1:0] raddr;
  } ram_port_t;

endpackage

### src/char_lcd_controller_write.sv
// Character LCD controller write path: top level.
// Depends on clcd_pkg, clcd_ctrl and clcd_ram.
//
// Usage: one command per transfer on the input channel (in_valid/in_ready,
// in_data): instruction write, data write, display cell read or glyph read.
// Every command yields exactly one result transfer on the output channel
// (out_valid/out_ready, out_data) with the read byte and the flags and
// counters as they stand after the command.
// Writes and out-of-range reads show their result in the cycle after the
// transfer; in-range reads pass through the registered RAM read and then the
// result register. A new command is taken at most every cycle for writes while
// the receiver keeps up; after an in-range read, input waits for the read state.
// The clear instruction fills the display RAM one cell a cycle, so input is
// held off until every display cell has been filled.
// After reset both RAMs are zeroed one entry a cycle; input is held off until
// the larger of the two RAMs has been swept.
// While the receiver stalls, the result stays registered and no command is
// taken until the result transfer completes or happens in the same cycle.
`timescale 1ns / 1ps

module char_lcd_controller_write import clcd_pkg::*; #(
  parameter int DISPLAY_CELLS = DEF_DISPLAY_CELLS,
  parameter int LINE_CELLS    = DEF_LINE_CELLS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ram_port_t  dram_port;
  ram_port_t  gram_port;
  logic [7:0] dram_rdata;
  logic [4:0] gram_rdata;

  // control and result stage
  clcd_ctrl #(
    .DISPLAY_CELLS(DISPLAY_CELLS),
    .LINE_CELLS   (LINE_CELLS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .dram_port (dram_port),
    .dram_rdata(dram_rdata),
    .gram_port (gram_port),
    .gram_rdata(gram_rdata)
  );

  // display RAM
  clcd_ram #(
    .DEPTH(DISPLAY_CELLS),
    .WIDTH(8)
  ) u_dram (
    .clk  (clk),
    .port (dram_port),
    .rdata(dram_rdata)
  );

  // glyph RAM
  clcd_ram #(
    .DEPTH(GLYPH_BYTES),
    .WIDTH(5)
  ) u_gram (
    .clk  (clk),
    .port (gram_port),
    .rdata(gram_rdata)
  );

endmodule

### src/clcd_ram.sv
// Single-port-write, registered-read RAM used for display and glyph storage.
// Depends on clcd_pkg for the request struct.
`timescale 1ns / 1ps

module clcd_ram import clcd_pkg::*; #(
  parameter int DEPTH = DEF_DISPLAY_CELLS,
  parameter int WIDTH = RAM_DW
) (
  input  logic             clk,
  input  ram_port_t        port,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr[AW-1:0]] <= port.wdata[WIDTH-1:0];
    end
    rdata <= mem[port.raddr[AW-1:0]];
  end

endmodule

### src/clcd_ctrl.sv
// Command decode, address counters, mode flags, RAM sweeps and result register.
// Depends on clcd_pkg; drives the display and glyph RAM ports.
`timescale 1ns / 1ps

module clcd_ctrl import clcd_pkg::*; #(
  parameter int DISPLAY_CELLS = DEF_DISPLAY_CELLS,
  parameter int LINE_CELLS    = DEF_LINE_CELLS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_t       in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data,
  output ram_port_t dram_port,
  input  logic [7:0] dram_rdata,
  output ram_port_t gram_port,
  input  logic [4:0] gram_rdata
);

  localparam int INIT_LEN = (DISPLAY_CELLS > GLYPH_BYTES) ? DISPLAY_CELLS : GLYPH_BYTES;
  localparam int CNT_W    = $clog2(INIT_LEN);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] sweep_cnt, sweep_cnt_next;
  logic [7:0]       sweep_addr;
  logic             read_glyph, read_glyph_next;

  logic       display_on, display_on_next;
  logic       cursor_on, cursor_on_next;
  logic       blink_on, blink_on_next;
  logic       two_lines, two_lines_next;
  logic       count_up, count_up_next;
  logic       display_selected, display_selected_next;
  logic [6:0] dd_counter, dd_counter_next;
  logic [5:0] cg_counter, cg_counter_next;

  logic       accept;
  logic       rd_disp_ok, rd_glyph_ok;
  logic [7:0] v;
  logic [7:0] col;
  logic [7:0] cell_idx;
  logic       cell_ok;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign v          = in_data.write_value;
  assign sweep_addr = 8'(sweep_cnt);

  // read range checks
  assign rd_disp_ok  = (in_data.command == CMD_READ_DISP) &&
                       ({1'b0, in_data.read_index} < 8'(DISPLAY_CELLS));
  assign rd_glyph_ok = (in_data.command == CMD_READ_GLYPH) &&
                       (in_data.read_index < 7'(GLYPH_BYTES));

  // display cell index for a data write at the current counter
  always_comb begin
    col      = {2'b00, dd_counter[5:0]};
    cell_idx = {1'b0, dd_counter};
    cell_ok  = cell_idx < 8'(DISPLAY_CELLS);
    if (two_lines) begin
      cell_idx = col + (dd_counter[6] ? 8'(LINE_CELLS) : 8'd0);
      cell_ok  = (col < 8'(LINE_CELLS)) && (cell_idx < 8'(DISPLAY_CELLS));
    end
  end

  // decode, counter stepping and RAM requests
  always_comb begin
    state_next            = state;
    sweep_cnt_next        = '0;
    read_glyph_next       = read_glyph;
    display_on_next       = display_on;
    cursor_on_next        = cursor_on;
    blink_on_next         = blink_on;
    two_lines_next        = two_lines;
    count_up_next         = count_up;
    display_selected_next = display_selected;
    dd_counter_next       = dd_counter;
    cg_counter_next       = cg_counter;
    dram_port             = '0;
    gram_port             = '0;
    dram_port.raddr       = in_data.read_index;
    gram_port.raddr       = in_data.read_index;

    case (state)
      S_INIT: begin
        dram_port.we    = sweep_addr < 8'(DISPLAY_CELLS);
        dram_port.waddr = sweep_addr[RAM_AW-1:0];
        gram_port.we    = sweep_addr < 8'(GLYPH_BYTES);
        gram_port.waddr = sweep_addr[RAM_AW-1:0];
        sweep_cnt_next  = sweep_cnt + 1'b1;
        if (sweep_cnt == CNT_W'(INIT_LEN - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        dram_port.we    = 1'b1;
        dram_port.waddr = sweep_addr[RAM_AW-1:0];
        dram_port.wdata = CLEAR_FILL;
        sweep_cnt_next  = sweep_cnt + 1'b1;
        if (sweep_addr == 8'(DISPLAY_CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_INSTR: begin
              if ((v & FSET_MASK) == FSET_CODE) begin
                two_lines_next = v[3];
              end else if ((v & DCTL_MASK) == DCTL_CODE) begin
                display_on_next = v[2];
                cursor_on_next  = v[1];
                blink_on_next   = v[0];
              end else if (v == CLEAR_CODE) begin
                dd_counter_next = '0;
                count_up_next   = 1'b0;
                state_next      = S_CLEAR;
              end else if (v == HOME_CODE) begin
                dd_counter_next = '0;
              end else if ((v & ENTRY_MASK) == ENTRY_CODE) begin
                count_up_next = v[1];
              end else if ((v & CGSET_MASK) == CGSET_CODE) begin
                cg_counter_next       = v[5:0];
                display_selected_next = 1'b0;
              end else if ((v & DDSET_MASK) == DDSET_MASK) begin
                dd_counter_next       = v[6:0];
                display_selected_next = 1'b1;
              end
            end
            CMD_DATA: begin
              if (display_selected) begin
                dram_port.we    = cell_ok;
                dram_port.waddr = cell_idx[RAM_AW-1:0];
                dram_port.wdata = v;
                dd_counter_next = count_up ? dd_counter + 1'b1 : dd_counter - 1'b1;
              end else begin
                gram_port.we    = 1'b1;
                gram_port.waddr = {1'b0, cg_counter};
                gram_port.wdata = {3'b000, v[4:0]};
                cg_counter_next = count_up ? cg_counter + 1'b1 : cg_counter - 1'b1;
              end
            end
            default: begin
              if (rd_disp_ok || rd_glyph_ok) begin
                read_glyph_next = rd_glyph_ok;
                state_next      = S_READ;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_INIT;
      sweep_cnt        <= '0;
      read_glyph       <= 1'b0;
      display_on       <= 1'b0;
      cursor_on        <= 1'b0;
      blink_on         <= 1'b0;
      two_lines        <= 1'b0;
      count_up         <= 1'b0;
      display_selected <= 1'b0;
      dd_counter       <= '0;
      cg_counter       <= '0;
    end else begin
      state            <= state_next;
      sweep_cnt        <= sweep_cnt_next;
      read_glyph       <= read_glyph_next;
      display_on       <= display_on_next;
      cursor_on        <= cursor_on_next;
      blink_on         <= blink_on_next;
      two_lines        <= two_lines_next;
      count_up         <= count_up_next;
      display_selected <= display_selected_next;
      dd_counter       <= dd_counter_next;
      cg_counter       <= cg_counter_next;
    end
  end

  // result register: loaded at accept, or in the read state that follows for an in-range RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_READ) begin
      out_valid <= 1'b1;
    end else if (accept && !rd_disp_ok && !rd_glyph_ok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_READ) || (accept && !rd_disp_ok && !rd_glyph_ok)) begin
      out_data.read_data        <= (state == S_READ) ?
                                   (read_glyph ? {3'b000, gram_rdata} : dram_rdata) : '0;
      out_data.display_on       <= display_on_next;
      out_data.cursor_on        <= cursor_on_next;
      out_data.blink_on         <= blink_on_next;
      out_data.two_lines        <= two_lines_next;
      out_data.count_up         <= count_up_next;
      out_data.display_selected <= display_selected_next;
      out_data.display_address  <= dd_counter_next;
      out_data.glyph_address    <= cg_counter_next;
    end
  end

endmodule

### src/clcd_checker.sv
// Port-level checks for the character LCD controller, bound to the top level.
// Depends on clcd_pkg for the payload types and codes.
`timescale 1ns / 1ps

module clcd_checker import clcd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a write command yields its result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready &&
    (in_data.command == CMD_INSTR || in_data.command == CMD_DATA) |=> out_valid)
    else $error("write result missing");

  // clear starts the fill sweep, so input is held off
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.command == CMD_INSTR &&
    in_data.write_value == CLEAR_CODE |=> !in_ready)
    else $error("input taken during clear sweep");

endmodule

bind char_lcd_controller_write clcd_checker u_clcd_checker (.*);

### tb/tb_char_lcd_controller_write.sv
// Testbench for char_lcd_controller_write: directed and random command traffic
// checked against a behavioral model of the controller. Depends on clcd_pkg.
`timescale 1ns / 1ps

module tb_char_lcd_controller_write;
  import clcd_pkg::*;

  localparam int NUM_CELLS = DEF_DISPLAY_CELLS;
  localparam int ROW_CELLS = DEF_LINE_CELLS;

  // instruction field bits
  localparam logic [7:0] FS_DATA_LEN = 8'h10;
  localparam logic [7:0] FS_TWO_LINE = 8'h08;
  localparam logic [7:0] FS_FONT     = 8'h04;
  localparam logic [7:0] DC_DISPLAY  = 8'h04;
  localparam logic [7:0] DC_CURSOR   = 8'h02;
  localparam logic [7:0] DC_BLINK    = 8'h01;
  localparam logic [7:0] EM_INCR     = 8'h02;
  localparam logic [7:0] EM_SHIFT    = 8'h01;
  localparam logic [7:0] NOP_CODE    = 8'h00;
  localparam logic [7:0] LINE2_BIT   = 8'h40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;

  // model state
  logic [7:0] disp_ram [NUM_CELLS];
  logic [4:0] glyph_ram [GLYPH_BYTES];
  logic [6:0] dd_addr = '0;
  logic [5:0] cg_addr = '0;
  logic       to_display = 1'b0;
  logic       display_en = 1'b0;
  logic       cursor_en = 1'b0;
  logic       blink_en = 1'b0;
  logic       two_line = 1'b0;
  logic       incr = 1'b0;

  out_t expected_status_q [$];

  char_lcd_controller_write uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    foreach (disp_ram[i]) disp_ram[i] = '0;
    foreach (glyph_ram[i]) glyph_ram[i] = '0;
  end

  // instruction decode of the model
  function automatic void model_instruction(input logic [7:0] v);
    if ((v & FSET_MASK) == FSET_CODE) begin
      two_line = v[3];
    end else if ((v & DCTL_MASK) == DCTL_CODE) begin
      display_en = v[2];
      cursor_en = v[1];
      blink_en = v[0];
    end else if (v == CLEAR_CODE) begin
      dd_addr = '0;
      incr = 1'b0;
      foreach (disp_ram[i]) disp_ram[i] = CLEAR_FILL;
    end else if (v == HOME_CODE) begin
      dd_addr = '0;
    end else if ((v & ENTRY_MASK) == ENTRY_CODE) begin
      incr = v[1];
    end else if ((v & CGSET_MASK) == CGSET_CODE) begin
      cg_addr = v[5:0];
      to_display = 1'b0;
    end else if ((v & DDSET_MASK) == DDSET_MASK) begin
      dd_addr = v[6:0];
      to_display = 1'b1;
    end
  endfunction

  // data write of the model, with line mapping and counter step
  function automatic void model_data(input logic [7:0] v);
    int col;
    int cell_pos;
    if (!to_display) begin
      glyph_ram[cg_addr] = v[4:0];
      cg_addr = incr ? cg_addr + 6'd1 : cg_addr - 6'd1;
    end else begin
      if (two_line) begin
        col = dd_addr[5:0];
        cell_pos = col + (dd_addr[6] ? ROW_CELLS : 0);
        if (col < ROW_CELLS && cell_pos < NUM_CELLS) disp_ram[cell_pos] = v;
      end else if (dd_addr < NUM_CELLS) begin
        disp_ram[dd_addr] = v;
      end
      dd_addr = incr ? dd_addr + 7'd1 : dd_addr - 7'd1;
    end
  endfunction

  // apply one command to the model and return the status it produces
  function automatic out_t predict_lcd(input in_t item);
    out_t r;
    r = '0;
    case (item.command)
      CMD_INSTR: model_instruction(item.write_value);
      CMD_DATA: model_data(item.write_value);
      CMD_READ_DISP: begin
        if (item.read_index < NUM_CELLS) r.read_data = disp_ram[item.read_index];
      end
      default: begin
        if (item.read_index < GLYPH_BYTES) r.read_data = {3'b000, glyph_ram[item.read_index]};
      end
    endcase
    r.display_on = display_en;
    r.cursor_on = cursor_en;
    r.blink_on = blink_en;
    r.two_lines = two_line;
    r.count_up = incr;
    r.display_selected = to_display;
    r.display_address = dd_addr;
    r.glyph_address = cg_addr;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) report_mismatch(field, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected transfer", out_data, 0);
      end else begin
        want = expected_status_q.pop_front();
        check_field("read_data", out_data.read_data, want.read_data);
        check_field("display_on", out_data.display_on, want.display_on);
        check_field("cursor_on", out_data.cursor_on, want.cursor_on);
        check_field("blink_on", out_data.blink_on, want.blink_on);
        check_field("two_lines", out_data.two_lines, want.two_lines);
        check_field("count_up", out_data.count_up, want.count_up);
        check_field("display_selected", out_data.display_selected, want.display_selected);
        check_field("display_address", out_data.display_address, want.display_address);
        check_field("glyph_address", out_data.glyph_address, want.glyph_address);
      end
    end
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] value,
                          input logic [6:0] index);
    in_t item;
    item.command = cmd;
    item.write_value = value;
    item.read_index = index;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    expected_status_q.push_back(predict_lcd(item));
  endtask

  task automatic send_instr(input logic [7:0] v);
    send_cmd(CMD_INSTR, v, 7'($urandom_range(0, 127)));
  endtask

  task automatic send_data(input logic [7:0] v);
    send_cmd(CMD_DATA, v, 7'($urandom_range(0, 127)));
  endtask

  task automatic test_reset_readback();
    send_cmd(CMD_READ_DISP, 8'hff, 7'd0);
    send_cmd(CMD_READ_DISP, 8'h00, 7'(NUM_CELLS - 1));
    send_cmd(CMD_READ_GLYPH, 8'hff, 7'(GLYPH_BYTES - 1));
  endtask

  task automatic test_instruction_decode();
    send_instr(FSET_CODE | FS_DATA_LEN | FS_TWO_LINE | FS_FONT);
    send_instr(FSET_CODE);
    send_instr(DCTL_CODE | DC_DISPLAY | DC_CURSOR | DC_BLINK);
    send_instr(DCTL_CODE);
    send_instr(ENTRY_CODE | EM_INCR | EM_SHIFT);
    send_instr(NOP_CODE);
    send_instr(HOME_CODE);
  endtask

  task automatic test_ram_addressing();
    // glyph write at the top address wraps the counter up to zero
    send_instr(CGSET_CODE | 8'h3f);
    send_data(8'hff);
    send_cmd(CMD_READ_GLYPH, 8'h00, 7'(GLYPH_BYTES - 1));
    // one-line: last cell written, top address dropped and wraps
    send_instr(DDSET_MASK | 8'(NUM_CELLS - 1));
    send_data(8'ha5);
    send_instr(DDSET_MASK | 8'h7f);
    send_data(8'h5a);
    // two-line: last column of line two kept, column past the line dropped
    send_instr(FSET_CODE | FS_TWO_LINE);
    send_instr(DDSET_MASK | LINE2_BIT | 8'(ROW_CELLS - 1));
    send_data(8'h81);
    send_data(8'h7e);
    // decrement from address zero wraps down
    send_instr(ENTRY_CODE);
    send_instr(DDSET_MASK);
    send_data(8'h33);
    send_cmd(CMD_READ_DISP, 8'h00, 7'(NUM_CELLS - 1));
    // clear, then reads past both RAM depths
    send_instr(CLEAR_CODE);
    send_cmd(CMD_READ_DISP, 8'h00, 7'h7f);
    send_cmd(CMD_READ_GLYPH, 8'h00, 7'(GLYPH_BYTES));
  endtask

  // random instruction, weighted toward ones that change addressing
  function automatic logic [7:0] random_instr();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 19))
      0, 1: return FSET_CODE | (r & 8'h1f);
      2, 3: return DCTL_CODE | (r & 8'h07);
      4: return CLEAR_CODE;
      5: return HOME_CODE;
      6, 7: return ENTRY_CODE | (r & 8'h03);
      8, 9, 10: return CGSET_CODE | (r & 8'h3f);
      11, 12, 13: return DDSET_MASK | r;
      14, 15, 16, 17:
        return DDSET_MASK | (r & LINE2_BIT) | 8'($urandom_range(0, ROW_CELLS - 1));
      18: return ($urandom_range(0, 1) != 0) ? (8'h10 | (r & 8'h0f)) : NOP_CODE;
      default: return r;
    endcase
  endfunction

  function automatic logic [6:0] random_index(input int depth);
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(depth, 127));
    return 7'($urandom_range(0, depth - 1));
  endfunction

  // mixed traffic: address-set bursts of data writes and reads, plus noise
  task automatic test_random_traffic(input int num_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < num_items) begin
      if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(2, 12);
        if ($urandom_range(0, 2) == 0) send_instr(CGSET_CODE | 8'($urandom_range(0, 63)));
        else send_instr(DDSET_MASK | 8'($urandom_range(0, 127)));
        repeat (burst) send_data(8'($urandom_range(0, 255)));
        repeat (burst / 2) begin
          if ($urandom_range(0, 1) != 0) send_cmd(CMD_READ_DISP, 8'($urandom_range(0, 255)),
                                                  random_index(NUM_CELLS));
          else send_cmd(CMD_READ_GLYPH, 8'($urandom_range(0, 255)),
                        random_index(GLYPH_BYTES));
        end
        sent += 1 + burst + burst / 2;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_data(8'($urandom_range(0, 255)));
          3, 4: send_cmd(CMD_READ_DISP, 8'($urandom_range(0, 255)), random_index(NUM_CELLS));
          5, 6: send_cmd(CMD_READ_GLYPH, 8'($urandom_range(0, 255)),
                         random_index(GLYPH_BYTES));
          default: send_instr(random_instr());
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    idle_pct = 7;
    stall_pct = 76;
    test_reset_readback();
    test_instruction_decode();
    test_ram_addressing();
    test_random_traffic(200);

    idle_pct = 76;
    stall_pct = 7;
    test_random_traffic(200);

    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(250);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_status_q.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
